// ----- rtl/core/drtd_pkg.sv -----
package drtd_pkg;

    localparam int unsigned CpW       = 21;
    localparam int unsigned NumPos    = 7;
    localparam int unsigned BankDepth = 14;
    localparam int unsigned NumSlots  = 16;
    localparam int unsigned SlotW     = 4;
    localparam int unsigned PosW      = 4;

    localparam logic [CpW-1:0] DeltaLimit  = 21'h000020;
    localparam logic [CpW-1:0] DeltaBias   = 21'h000010;
    localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
    localparam logic [PosW-1:0] TargetBase = 4'd7;

    typedef logic [BankDepth-1:0][CpW-1:0] t_cp_bank;

    typedef struct packed {
        logic            clear;
        logic            we;
        logic [PosW-1:0] idx;
        logic [CpW-1:0]  raw;
    } t_prev_ctl;

endpackage

// ----- rtl/core/drtd_ram.sv -----
module drtd_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/drtd_prev.sv -----
module drtd_prev (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drtd_pkg::t_prev_ctl i_ctl,
    output drtd_pkg::t_cp_bank  o_bank
);

    drtd_pkg::t_cp_bank         r_bank;
    logic [drtd_pkg::CpW-1:0]   n_value;
    logic [drtd_pkg::CpW-1:0]   prev;

    always_comb begin
        prev = r_bank[i_ctl.idx];
        if (i_ctl.raw < drtd_pkg::DeltaLimit) begin
            n_value = prev + i_ctl.raw - drtd_pkg::DeltaBias;
        end else begin
            n_value = i_ctl.raw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_bank <= '0;
        end else if (i_ctl.we) begin
            r_bank[i_ctl.idx] <= n_value;
        end
    end

    assign o_bank = r_bank;

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.we |-> i_ctl.idx < 4'(drtd_pkg::BankDepth))
        else $error("prev bank index out of range");

endmodule

// ----- rtl/core/delta_replay_table_decoder.sv -----
// channel  dir  handshake             payload
// in       in   i_in_valid/o_in_stall  i_byte_value
// out      out  o_out_valid/i_out_stall  source/target fields, last_of_run, table_end
// literal value byte: taken while idle, a finished result adds the S_EMIT step
// replay: S_RCNT, then per run an S_RREAD and S_RAPPLY pair per value for the slot memory read
// reset clears control and prev values; slot contents are valid only after written
// a stalled result holds the emit step, so the input stalls while it waits
module delta_replay_table_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_source_count,
    output logic [62:0] o_source_first_three,
    output logic [62:0] o_source_next_three,
    output logic [20:0] o_source_seventh,
    output logic [2:0]  o_target_count,
    output logic [62:0] o_target_first_three,
    output logic [62:0] o_target_next_three,
    output logic [20:0] o_target_seventh,
    output logic        o_last_of_run,
    output logic        o_table_end
);

    typedef enum logic [2:0] {S_IDLE, S_RCNT, S_RREAD, S_RAPPLY, S_EMIT} t_state;

    t_state      r_state;
    logic        r_phase;
    logic [3:0]  r_next_slot;
    logic [15:0] r_slot_ok;
    logic [5:0]  r_counts;
    logic [3:0]  r_pos;
    logic [20:0] r_partial;
    logic [1:0]  r_left;
    logic [3:0]  r_slot;
    logic [2:0]  r_run;
    logic        r_last;
    logic        r_end;

    logic        r_out_valid;
    logic [2:0]  r_src_cnt, r_tgt_cnt;
    logic [6:0][20:0] r_src, r_tgt;
    logic        r_out_last, r_out_end;

    logic        acc, cp_done, head_end, head_rep, head_lit, out_free, emit_go;
    logic [7:0]  b;
    logic [20:0] cp, ext, n_partial;
    logic [1:0]  n_left;
    logic [3:0]  total, lit_total, pos_inc, bank_idx, cur_slot;
    logic [5:0]  cnt_rdata;
    logic [20:0] raw_rdata;
    drtd_pkg::t_prev_ctl prev_ctl;
    drtd_pkg::t_cp_bank  bank;
    logic [6:0][20:0] src_pack, tgt_pack;

    assign b        = i_byte_value;
    assign acc      = i_in_valid && (r_state == S_IDLE);
    assign head_end = !r_phase && (b == 8'h00);
    assign head_rep = !r_phase && b[7];
    assign head_lit = !r_phase && !b[7] && (b != 8'h00);
    assign total    = {1'b0, r_counts[5:3]} + {1'b0, r_counts[2:0]};
    assign lit_total = {1'b0, b[5:3]} + {1'b0, b[2:0]};
    assign pos_inc  = r_pos + 4'd1;
    assign cur_slot = r_next_slot - 4'd1;
    assign ext      = {r_partial[14:0], b[5:0]};
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_go  = (r_state == S_EMIT) && out_free;

    always_comb begin
        cp        = '0;
        cp_done   = 1'b0;
        n_partial = r_partial;
        n_left    = r_left;
        if (r_left == 2'd0) begin
            if (!b[7]) begin
                cp      = {13'b0, b};
                cp_done = 1'b1;
            end else if (b[7:5] == 3'b110) begin
                n_partial = {16'b0, b[4:0]};
                n_left    = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
                n_partial = {17'b0, b[3:0]};
                n_left    = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
                n_partial = {18'b0, b[2:0]};
                n_left    = 2'd3;
            end else begin
                cp      = drtd_pkg::Replacement;
                cp_done = 1'b1;
            end
        end else begin
            n_left = r_left - 2'd1;
            if (r_left == 2'd1) begin
                cp        = ext;
                cp_done   = 1'b1;
                n_partial = '0;
            end else begin
                n_partial = ext;
            end
        end
    end

    always_comb begin
        if (r_pos < {1'b0, r_counts[5:3]}) begin
            bank_idx = r_pos;
        end else begin
            bank_idx = r_pos - {1'b0, r_counts[5:3]} + drtd_pkg::TargetBase;
        end
        prev_ctl.clear = acc && head_end;
        prev_ctl.we    = (acc && r_phase && cp_done) || (r_state == S_RAPPLY);
        prev_ctl.idx   = bank_idx;
        prev_ctl.raw   = (r_state == S_RAPPLY) ? raw_rdata : cp;
    end

    always_comb begin
        for (int i = 0; i < 7; i++) begin
            src_pack[i] = (3'(i) < r_counts[5:3]) ? bank[i] : '0;
            tgt_pack[i] = (3'(i) < r_counts[2:0]) ? bank[i + 7] : '0;
        end
    end

    drtd_ram #(.Width(6), .Depth(16)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (acc && head_lit),
        .i_waddr (r_next_slot),
        .i_wdata (b[5:0]),
        .i_raddr (b[3:0]),
        .o_rdata (cnt_rdata)
    );

    drtd_ram #(.Width(21), .Depth(256)) u_raw_ram (
        .i_clk   (i_clk),
        .i_we    (acc && r_phase && cp_done),
        .i_waddr ({cur_slot, r_pos}),
        .i_wdata (cp),
        .i_raddr ({r_slot, r_pos}),
        .o_rdata (raw_rdata)
    );

    drtd_prev u_prev (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (prev_ctl),
        .o_bank  (bank)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_next_slot <= '0;
            r_slot_ok   <= '0;
            r_counts    <= '0;
            r_pos       <= '0;
            r_partial   <= '0;
            r_left      <= '0;
            r_slot      <= '0;
            r_run       <= '0;
            r_last      <= 1'b0;
            r_end       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        if (head_end) begin
                            r_next_slot <= '0;
                            r_slot_ok   <= '0;
                            r_counts    <= '0;
                            r_pos       <= '0;
                            r_partial   <= '0;
                            r_left      <= '0;
                            r_last      <= 1'b1;
                            r_end       <= 1'b1;
                            r_state     <= S_EMIT;
                        end else if (head_rep) begin
                            r_slot  <= b[3:0];
                            r_run   <= b[6:4];
                            r_end   <= 1'b0;
                            r_state <= S_RCNT;
                        end else if (head_lit) begin
                            r_counts               <= b[5:0];
                            r_slot_ok[r_next_slot] <= 1'b1;
                            r_next_slot            <= r_next_slot + 4'd1;
                            r_pos                  <= '0;
                            r_partial              <= '0;
                            r_left                 <= '0;
                            r_end                  <= 1'b0;
                            if (lit_total == 4'd0) begin
                                r_last  <= 1'b1;
                                r_state <= S_EMIT;
                            end else begin
                                r_phase <= 1'b1;
                            end
                        end else begin
                            r_partial <= n_partial;
                            r_left    <= n_left;
                            if (cp_done) begin
                                if (pos_inc >= total) begin
                                    r_phase <= 1'b0;
                                    r_pos   <= '0;
                                    r_last  <= 1'b1;
                                    r_state <= S_EMIT;
                                end else begin
                                    r_pos <= pos_inc;
                                end
                            end
                        end
                    end
                end
                S_RCNT: begin
                    r_counts <= r_slot_ok[r_slot] ? cnt_rdata : '0;
                    r_pos    <= '0;
                    r_state  <= S_RREAD;
                end
                S_RREAD: begin
                    if (r_pos >= total) begin
                        r_last  <= (r_run == 3'd0);
                        r_state <= S_EMIT;
                    end else begin
                        r_state <= S_RAPPLY;
                    end
                end
                S_RAPPLY: begin
                    r_pos   <= pos_inc;
                    r_state <= S_RREAD;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_src_cnt   <= r_counts[5:3];
                        r_tgt_cnt   <= r_counts[2:0];
                        r_src       <= src_pack;
                        r_tgt       <= tgt_pack;
                        r_out_last  <= r_last;
                        r_out_end   <= r_end;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_run   <= r_run - 3'd1;
                            r_pos   <= '0;
                            r_state <= S_RREAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall           = (r_state != S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_source_count       = r_src_cnt;
    assign o_source_first_three = {r_src[2], r_src[1], r_src[0]};
    assign o_source_next_three  = {r_src[5], r_src[4], r_src[3]};
    assign o_source_seventh     = r_src[6];
    assign o_target_count       = r_tgt_cnt;
    assign o_target_first_three = {r_tgt[2], r_tgt[1], r_tgt[0]};
    assign o_target_next_three  = {r_tgt[5], r_tgt[4], r_tgt[3]};
    assign o_target_seventh     = r_tgt[6];
    assign o_last_of_run        = r_out_last;
    assign o_table_end          = r_out_end;

    a_phase_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase |-> total != 4'd0)
        else $error("value phase with empty record");

    a_left_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != 2'd0) |-> r_phase)
        else $error("utf-8 continuation outside a record");

    a_apply_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RAPPLY) |-> r_pos < total)
        else $error("replay past record end");

    a_end_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_table_end) |-> (o_source_count == 3'd0 && o_target_count == 3'd0
            && o_last_of_run))
        else $error("end marker with mapping content");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    logic [2:0]  src_count;
    logic [62:0] src_first;
    logic [62:0] src_next;
    logic [20:0] src_seventh;
    logic [2:0]  tgt_count;
    logic [62:0] tgt_first;
    logic [62:0] tgt_next;
    logic [20:0] tgt_seventh;
    logic        last_of_run;
    logic        table_end;
} t_mapping;

class mapping_scoreboard;
    logic [20:0] prev_src [7];
    logic [20:0] prev_tgt [7];
    logic [5:0]  slot_counts [16];
    logic [20:0] slot_raw [16][14];
    bit          slot_written [16];
    logic [3:0]  next_slot;
    bit          in_record;
    logic [20:0] utf8_acc;
    int          utf8_left;
    int          rec_pos;
    logic [5:0]  rec_counts;
    t_mapping    expected_maps[$];
    int          mismatches;

    function new();
        mismatches = 0;
        clear_state();
    endfunction

    function void clear_state();
        foreach (prev_src[i]) begin
            prev_src[i] = '0;
            prev_tgt[i] = '0;
        end
        foreach (slot_counts[s]) begin
            slot_counts[s] = '0;
            slot_written[s] = 0;
            for (int p = 0; p < 14; p++) slot_raw[s][p] = '0;
        end
        next_slot = '0;
        in_record = 0;
        utf8_acc = '0;
        utf8_left = 0;
        rec_pos = 0;
        rec_counts = '0;
    endfunction

    function logic [20:0] apply_delta(logic [20:0] prv, logic [20:0] raw);
        if (raw < drtd_pkg::DeltaLimit) return prv + raw - drtd_pkg::DeltaBias;
        return raw;
    endfunction

    function void take_value(int p, logic [20:0] raw, logic [5:0] c);
        int f;
        f = c[5:3];
        if (p < f) prev_src[p] = apply_delta(prev_src[p], raw);
        else if (p - f < 7) prev_tgt[p-f] = apply_delta(prev_tgt[p-f], raw);
    endfunction

    function void push_mapping(logic [5:0] c, bit last);
        logic [6:0][20:0] s;
        logic [6:0][20:0] t;
        t_mapping m;
        s = '0;
        t = '0;
        for (int i = 0; i < 7; i++) begin
            if (i < c[5:3]) s[i] = prev_src[i];
            if (i < c[2:0]) t[i] = prev_tgt[i];
        end
        m.src_count = c[5:3];
        m.src_first = s[2:0];
        m.src_next = s[5:3];
        m.src_seventh = s[6];
        m.tgt_count = c[2:0];
        m.tgt_first = t[2:0];
        m.tgt_next = t[5:3];
        m.tgt_seventh = t[6];
        m.last_of_run = last;
        m.table_end = 0;
        expected_maps.push_back(m);
    endfunction

    function void note_input(logic [7:0] b);
        t_mapping m;
        logic [20:0] cp;
        logic [3:0] sl;
        int runs;
        int total;
        if (!in_record) begin
            if (b == 8'h00) begin
                clear_state();
                m = '0;
                m.last_of_run = 1;
                m.table_end = 1;
                expected_maps.push_back(m);
            end else if (b[7]) begin
                sl = b[3:0];
                runs = b[6:4] + 1;
                total = slot_counts[sl][5:3] + slot_counts[sl][2:0];
                for (int k = 0; k < runs; k++) begin
                    for (int p = 0; p < total; p++)
                        take_value(p, slot_raw[sl][p], slot_counts[sl]);
                    push_mapping(slot_counts[sl], k + 1 == runs);
                end
            end else begin
                rec_counts = b[5:0];
                slot_counts[next_slot] = rec_counts;
                slot_written[next_slot] = 1;
                next_slot++;
                rec_pos = 0;
                utf8_acc = '0;
                utf8_left = 0;
                if (rec_counts[5:3] + rec_counts[2:0] == 0) push_mapping(rec_counts, 1);
                else in_record = 1;
            end
            return;
        end
        if (utf8_left == 0) begin
            if (b < 8'h80) cp = b;
            else if (b[7:5] == 3'b110) begin
                utf8_acc = b[4:0];
                utf8_left = 1;
                return;
            end else if (b[7:4] == 4'b1110) begin
                utf8_acc = b[3:0];
                utf8_left = 2;
                return;
            end else if (b[7:3] == 5'b11110) begin
                utf8_acc = b[2:0];
                utf8_left = 3;
                return;
            end else cp = drtd_pkg::Replacement;
        end else begin
            utf8_acc = {utf8_acc[14:0], b[5:0]};
            utf8_left--;
            if (utf8_left != 0) return;
            cp = utf8_acc;
            utf8_acc = '0;
        end
        sl = next_slot - 4'd1;
        total = rec_counts[5:3] + rec_counts[2:0];
        if (rec_pos < 14) slot_raw[sl][rec_pos] = cp;
        take_value(rec_pos, cp, rec_counts);
        rec_pos = (rec_pos + 1) & 15;
        if (rec_pos >= total) begin
            in_record = 0;
            rec_pos = 0;
            push_mapping(rec_counts, 1);
        end
    endfunction

    function void check_result(t_mapping got);
        t_mapping want;
        if (expected_maps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected mapping %p", got);
            return;
        end
        want = expected_maps.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mapping mismatch\n  exp %p\n  got %p", want, got);
        end
    endfunction
endclass

module tb_top;
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic        o_in_stall;
    logic [7:0]  i_byte_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 0;
    t_mapping    out_map;
    mapping_scoreboard sb = new();
    int          idle_cycles = 0;
    bit          sender_calm = 0;

    delta_replay_table_decoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_byte_value(i_byte_value),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_source_count(out_map.src_count), .o_source_first_three(out_map.src_first),
        .o_source_next_three(out_map.src_next), .o_source_seventh(out_map.src_seventh),
        .o_target_count(out_map.tgt_count), .o_target_first_three(out_map.tgt_first),
        .o_target_next_three(out_map.tgt_next), .o_target_seventh(out_map.tgt_seventh),
        .o_last_of_run(out_map.last_of_run), .o_table_end(out_map.table_end)
    );

    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [7:0] pick_byte();
        int roll;
        int sl;
        roll = $urandom_range(0, 99);
        if (!sb.in_record) begin
            if (roll < 3) return 8'h00;
            if (roll < 35) begin
                sl = $urandom_range(0, 15);
                for (int i = 0; i < 16; i++) begin
                    if (sb.slot_written[(sl + i) % 16]) begin
                        sl = (sl + i) % 16;
                        if ($urandom_range(0, 9) == 0)
                            return {1'b1, 3'd7, 4'(sl)};
                        return {1'b1, 3'($urandom_range(0, 2)), 4'(sl)};
                    end
                end
            end
            return 8'($urandom_range(1, 127));
        end
        if (sb.utf8_left > 0) begin
            if (roll < 92) return {2'b10, 6'($urandom_range(0, 63))};
            return 8'($urandom);
        end
        if (roll < 35) return 8'($urandom_range(0, 8'h1f));
        if (roll < 55) return 8'($urandom_range(8'h20, 8'h7f));
        if (roll < 67) return 8'($urandom_range(8'hc0, 8'hdf));
        if (roll < 79) return 8'($urandom_range(8'he0, 8'hef));
        if (roll < 89) return 8'($urandom_range(8'hf0, 8'hf7));
        if (roll < 94) return 8'($urandom_range(8'h80, 8'hbf));
        return 8'($urandom_range(8'hf8, 8'hff));
    endfunction

    task automatic send_byte(logic [7:0] b);
        int gap;
        i_in_valid <= 1;
        i_byte_value <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(b);
        gap = sender_calm ? 0 : gap_len();
        if (gap > 0) begin
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // output side: random stalls, one long hold-off
    initial begin
        int n;
        n = 0;
        @(posedge i_clk iff i_rst_n);
        while (1) begin
            @(posedge i_clk);
            n++;
            if (n == 300) begin
                i_out_stall <= 1;
                repeat (400) @(posedge i_clk);
            end else if (n % 1000 < 200) i_out_stall <= 0;
            else i_out_stall <= (gap_len() > 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sb.check_result(out_map);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        logic [7:0] opening[$];
        opening = '{8'h00, 8'h40, 8'h3f,
                    8'h00, 8'h1f, 8'h20, 8'h7f, 8'hc2, 8'h80, 8'hdf, 8'hbf,
                    8'he0, 8'h80, 8'h80, 8'hef, 8'hbf, 8'hbf,
                    8'hf0, 8'h90, 8'h80, 8'h80, 8'hf7, 8'hbf, 8'hbf, 8'hbf,
                    8'h80, 8'hbf, 8'hf8, 8'hff,
                    8'h78, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
                    8'hf1, 8'h80, 8'h82, 8'h00};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        foreach (opening[i]) send_byte(opening[i]);
        for (int i = 0; i < 300; i++) begin
            if (i % 50 == 0) sender_calm = !sender_calm;
            if (i == 150) begin
                i_in_valid <= 0;
                @(posedge i_clk);
                while (sb.expected_maps.size() != 0) @(posedge i_clk);
            end
            send_byte(pick_byte());
        end
        i_in_valid <= 0;
        while (sb.expected_maps.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_maps.size() == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
